// ===== rtl/core/wcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Wash cycle sequencer package
// Shared types, phase codes, duration sets and helper functions.
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int NumPhases = 4;
  localparam int IdxW      = $clog2(NumPhases);
  localparam int CntW      = 3;
  localparam int DispW     = 4;
  localparam int LinesW    = 5;
  localparam int PhaseW    = 4;
  localparam int ReqW      = 2;
  localparam int BtnW      = 3;

  localparam logic [7:0]        BcdPortKeep = 8'hE1;
  localparam logic [LinesW-1:0] LineMotor   = 5'b00001;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK  = 2'd0,
    REQ_PRESS = 2'd1,
    REQ_MODE  = 2'd2
  } req_e;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b0000000001,
    PH_FILL    = 10'b0000000010,
    PH_FILL_P  = 10'b0000000100,
    PH_WASH    = 10'b0000001000,
    PH_WASH_P  = 10'b0000010000,
    PH_RINSE   = 10'b0000100000,
    PH_RINSE_P = 10'b0001000000,
    PH_SPIN    = 10'b0010000000,
    PH_SPIN_P  = 10'b0100000000,
    PH_DONE    = 10'b1000000000
  } phase_e;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [DispW-1:0]  bcd;
    logic [LinesW-1:0] lines;
  } res_t;

  function automatic logic [CntW-1:0] dur_of(input logic [1:0] set,
                                             input logic [IdxW-1:0] idx);
    logic [CntW-1:0] d;
    case (set)
      2'd0: begin
        case (idx)
          2'd0:    d = 3'd1;
          2'd1:    d = 3'd3;
          2'd2:    d = 3'd2;
          default: d = 3'd3;
        endcase
      end
      2'd1: begin
        case (idx)
          2'd0:    d = 3'd2;
          2'd1:    d = 3'd5;
          2'd2:    d = 3'd4;
          default: d = 3'd5;
        endcase
      end
      default: begin
        case (idx)
          2'd0:    d = 3'd3;
          2'd1:    d = 3'd7;
          2'd2:    d = 3'd5;
          default: d = 3'd6;
        endcase
      end
    endcase
    return d;
  endfunction

  function automatic logic [LinesW-1:0] lines_for(input logic [IdxW-1:0] idx);
    logic [LinesW-1:0] l;
    l = LinesW'(2) << idx;
    if (idx != '0) begin
      l = l | LineMotor;
    end
    return l;
  endfunction

  function automatic logic [DispW-1:0] show_digit(input logic [CntW-1:0] v);
    logic [7:0] port;
    port = (8'(v) << 1) & ~BcdPortKeep;
    return port[4:1];
  endfunction

  function automatic logic [IdxW-1:0] phase_idx(input phase_e ph);
    logic [IdxW-1:0] i;
    case (ph)
      PH_WASH, PH_WASH_P:   i = 2'd1;
      PH_RINSE, PH_RINSE_P: i = 2'd2;
      PH_SPIN, PH_SPIN_P:   i = 2'd3;
      default:              i = 2'd0;
    endcase
    return i;
  endfunction

  function automatic phase_e run_of(input logic [IdxW-1:0] idx);
    phase_e p;
    case (idx)
      2'd0:    p = PH_FILL;
      2'd1:    p = PH_WASH;
      2'd2:    p = PH_RINSE;
      default: p = PH_SPIN;
    endcase
    return p;
  endfunction

  function automatic phase_e pause_of(input logic [IdxW-1:0] idx);
    phase_e p;
    case (idx)
      2'd0:    p = PH_FILL_P;
      2'd1:    p = PH_WASH_P;
      2'd2:    p = PH_RINSE_P;
      default: p = PH_SPIN_P;
    endcase
    return p;
  endfunction

  function automatic logic [PhaseW-1:0] phase_num(input phase_e ph);
    logic [PhaseW-1:0] n;
    unique case (ph)
      PH_IDLE:    n = 4'd0;
      PH_FILL:    n = 4'd1;
      PH_FILL_P:  n = 4'd2;
      PH_WASH:    n = 4'd3;
      PH_WASH_P:  n = 4'd4;
      PH_RINSE:   n = 4'd5;
      PH_RINSE_P: n = 4'd6;
      PH_SPIN:    n = 4'd7;
      PH_SPIN_P:  n = 4'd8;
      PH_DONE:    n = 4'd9;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/wcs_state.sv =====
// ----------------------------------------------------------------------------
// Wash cycle sequencer state
// Phase machine, phase counters, durations, display and drive lines.
// ----------------------------------------------------------------------------
module wcs_state import wcs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [ReqW-1:0] req_type_i,
  input  logic [BtnW-1:0] buttons_i,
  output res_t            res_o
);

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   cnt_q [NumPhases];
  logic [CntW-1:0]   cnt_d [NumPhases];
  logic [CntW-1:0]   dur_q [NumPhases];
  logic [CntW-1:0]   dur_d [NumPhases];
  logic [DispW-1:0]  disp_q, disp_d;
  logic [LinesW-1:0] lines_q, lines_d;

  logic [IdxW-1:0]   idx;
  logic [CntW-1:0]   cnt_inc;
  logic [1:0]        set;
  logic              running;
  logic              paused;
  logic              below;

  assign idx     = phase_idx(phase_q);
  assign cnt_inc = cnt_q[idx] + CntW'(1);
  assign below   = cnt_q[idx] < dur_q[idx];
  assign running = (phase_q == PH_FILL) || (phase_q == PH_WASH) ||
                   (phase_q == PH_RINSE) || (phase_q == PH_SPIN);
  assign paused  = (phase_q == PH_FILL_P) || (phase_q == PH_WASH_P) ||
                   (phase_q == PH_RINSE_P) || (phase_q == PH_SPIN_P);
  assign set     = buttons_i[0] ? 2'd0 : (buttons_i[1] ? 2'd1 : 2'd2);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    dur_d   = dur_q;
    disp_d  = disp_q;
    lines_d = lines_q;
    if (accept_i) begin
      unique case (req_e'(req_type_i))
        REQ_MODE: begin
          if ((phase_q == PH_IDLE) && (buttons_i != '0)) begin
            for (int i = 0; i < NumPhases; i++) begin
              dur_d[i] = dur_of(set, IdxW'(i));
            end
          end
        end
        REQ_PRESS: begin
          if ((phase_q == PH_IDLE) || paused) begin
            phase_d = run_of(idx);
            lines_d = below ? lines_for(idx) : '0;
          end else if (running) begin
            phase_d = pause_of(idx);
            lines_d = '0;
          end
        end
        REQ_TICK: begin
          if (running) begin
            if (below) begin
              cnt_d[idx] = cnt_inc;
              lines_d    = lines_q | lines_for(idx);
              disp_d     = show_digit(cnt_inc);
            end else begin
              lines_d = '0;
              disp_d  = show_digit('0);
              if (idx == 2'd0) begin
                cnt_d[1] = '0;
              end
              phase_d = (idx == 2'd3) ? PH_DONE : run_of(idx + IdxW'(1));
            end
          end else if (phase_q == PH_DONE) begin
            for (int i = 0; i < NumPhases; i++) begin
              cnt_d[i] = '0;
            end
            disp_d  = show_digit('0);
            lines_d = '0;
            phase_d = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      disp_q  <= '0;
      lines_q <= '0;
      for (int i = 0; i < NumPhases; i++) begin
        cnt_q[i] <= '0;
        dur_q[i] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      disp_q  <= disp_d;
      lines_q <= lines_d;
      cnt_q   <= cnt_d;
      dur_q   <= dur_d;
    end
  end

  assign res_o.phase = phase_num(phase_d);
  assign res_o.bcd   = disp_d;
  assign res_o.lines = lines_d;

  a_cnt_within_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= dur_q[0]) && (cnt_q[1] <= dur_q[1]) &&
    (cnt_q[2] <= dur_q[2]) && (cnt_q[3] <= dur_q[3]))
    else $error("phase count beyond its duration");

  a_lines_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lines_q != '0) |-> running)
    else $error("drive lines on outside a running phase");

  a_one_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(lines_q[4:1]))
    else $error("more than one phase LED on");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |->
      ((cnt_q[0] == '0) && (cnt_q[1] == '0) && (cnt_q[2] == '0) && (cnt_q[3] == '0)))
    else $error("counts not clear in idle");

endmodule

// ===== rtl/core/wash_cycle_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// Wash cycle sequencer core
// An accepted word's result is registered in the output or the skid register.
// Throughput: one word per cycle while the skid register is empty.
// A skid register behind the output takes one word while the output stalls;
// the input then stalls for every cycle in which that skid word is held.
// Reset clears the phase to idle, all counts and durations, display and lines.
// ----------------------------------------------------------------------------
module wash_cycle_sequencer_core import wcs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [ReqW-1:0] req_type_i,
  input  logic [BtnW-1:0] buttons_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PhaseW-1:0] phase_o,
  output logic [DispW-1:0]  bcd_digit_o,
  output logic            motor_on_o,
  output logic            led_fill_o,
  output logic            led_wash_o,
  output logic            led_rinse_o,
  output logic            led_spin_o
);

  res_t res;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  logic in_acc;
  logic out_fire;

  assign in_acc   = in_valid_i & ~skid_valid_q;
  assign out_fire = out_valid_q & ~out_stall_i;

  wcs_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_acc),
    .req_type_i (req_type_i),
    .buttons_i  (buttons_i),
    .res_o      (res)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_fire) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign phase_o     = out_q.phase;
  assign bcd_digit_o = out_q.bcd;
  assign motor_on_o  = out_q.lines[0];
  assign led_fill_o  = out_q.lines[1];
  assign led_wash_o  = out_q.lines[2];
  assign led_rinse_o = out_q.lines[3];
  assign led_spin_o  = out_q.lines[4];

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted word produced no result");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("word accepted under stall was not queued");

endmodule
